/* rtl/sab_pkg.sv */
// Shared types and constants for the superpixel adjacency builder.
// No dependencies; every other file in rtl/ imports this package.
package sab_pkg;

  // Fixed field widths of the request and response beats.
  localparam int LABEL_W    = 8;
  localparam int ACTION_W   = 2;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CMP_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Defaults for the top-level parameters.
  localparam int DEF_NUM_LABELS = 256;
  localparam int DEF_MAX_WIDTH  = 1024;

  // Register reset values and limits.
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 11'd2;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 13'd2;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_PIXEL = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Request beat.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LABEL_W-1:0]  pixel_label;
    logic [LABEL_W-1:0]  query_first;
    logic [LABEL_W-1:0]  query_second;
  } in_t;

  // Response beat.
  typedef struct packed {
    logic adjacent;
    logic frame_complete;
  } out_t;

  // 2x2 window handed from the raster tracker to the sequencer.
  typedef struct packed {
    logic               valid;
    logic               mark;
    logic               on_edge;
    logic [LABEL_W-1:0] ul;
    logic [LABEL_W-1:0] ll;
    logic [LABEL_W-1:0] lr;
    logic [LABEL_W-1:0] ur;
  } win_t;

endpackage

/* rtl/sab_adj_mem.sv */
// Adjacency store: one row per label, upper triangle only, with row valid bits.
// Read-modify-write pipeline with forwarding of the last write. Uses sab_pkg.
module sab_adj_mem import sab_pkg::*; #(
  parameter int NUM_LABELS = DEF_NUM_LABELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          rd_valid,
  input  logic                          rd_query,
  input  logic [$clog2(NUM_LABELS)-1:0] rd_row,
  input  logic [$clog2(NUM_LABELS)-1:0] rd_col,
  output logic                          hit_valid,
  output logic                          hit,
  output logic                          busy
);

  localparam int LBL_W = $clog2(NUM_LABELS);

  logic [NUM_LABELS-1:0] mem [NUM_LABELS];
  logic [NUM_LABELS-1:0] mem_q;
  logic [NUM_LABELS-1:0] row_valid;

  logic                  s1_valid;
  logic                  s1_query;
  logic [LBL_W-1:0]      s1_row;
  logic [LBL_W-1:0]      s1_col;
  logic                  s1_rv;

  logic                  fwd_valid;
  logic [LBL_W-1:0]      fwd_row;
  logic [NUM_LABELS-1:0] fwd_data;

  logic [NUM_LABELS-1:0] base;
  logic [NUM_LABELS-1:0] new_row;
  logic                  wr_en;

  // Current row contents: the write of the last edge wins over the RAM output,
  // and a row never written since the last clear reads as zero.
  always_comb begin
    if (fwd_valid && (fwd_row == s1_row)) begin
      base = fwd_data;
    end else if (s1_rv) begin
      base = mem_q;
    end else begin
      base = '0;
    end
    new_row = base | (NUM_LABELS'(1) << s1_col);
  end

  assign wr_en     = s1_valid && !s1_query;
  assign hit_valid = s1_valid && s1_query;
  assign hit       = base[s1_col];
  assign busy      = wr_en;

  // Control state and row valid bits.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      s1_valid  <= rd_valid;
      fwd_valid <= wr_en;
      if (wr_en) begin
        row_valid[s1_row] <= 1'b1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_query <= rd_query;
    s1_row   <= rd_row;
    s1_col   <= rd_col;
    s1_rv    <= row_valid[rd_row];
    fwd_row  <= s1_row;
    fwd_data <= new_row;
  end

  // Row RAM: one read port, one write port, registered read data.
  always_ff @(posedge clk) begin
    mem_q <= mem[rd_row];
    if (wr_en) begin
      mem[s1_row] <= new_row;
    end
  end

  // A response only follows a query read.
  a_hit_from_query: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> $past(rd_valid && rd_query))
    else $error("adjacency response without a query read");

  // A clear must never cut off a pending write.
  a_no_clear_on_write: assert property (@(posedge clk) disable iff (rst)
    clear |-> !wr_en)
    else $error("clear while an adjacency write is pending");

  // A written row is valid afterwards.
  a_row_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && !clear |=> row_valid[$past(s1_row)])
    else $error("row not marked valid after write");

endmodule

/* rtl/sab_scan.sv */
// Raster tracker: column and row counters, previous-row label RAM and the
// left and upper-left labels; produces one 2x2 window per taken pixel. Uses sab_pkg.
module sab_scan import sab_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                pix_valid,
  input  logic [LABEL_W-1:0]  pix_label,
  input  logic [WIDTH_W-1:0]  image_width,
  input  logic [HEIGHT_W-1:0] image_height,
  output logic                frame_done,
  output win_t                win
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [LABEL_W-1:0]  prev_row [MAX_WIDTH];
  logic [LABEL_W-1:0]  prev_q;

  logic [COL_W-1:0]    col;
  logic [HEIGHT_W-1:0] row;
  logic [LABEL_W-1:0]  left_label;
  logic [LABEL_W-1:0]  upper_left_label;

  logic                s_valid;
  logic                s_mark;
  logic                s_edge;
  logic [COL_W-1:0]    s_col;
  logic [LABEL_W-1:0]  s_ul;
  logic [LABEL_W-1:0]  s_ll;
  logic [LABEL_W-1:0]  s_lr;

  logic [CMP_W-1:0]    width_c;
  logic                wrap;
  logic [COL_W-1:0]    col_w;
  logic [HEIGHT_W-1:0] row_w;
  logic                done_w;
  logic                take;
  logic [CMP_W-1:0]    col_inc;
  logic                end_row;
  logic                on_edge;
  logic                mark;

  // Position of the incoming pixel, after a wrap left over by a shrunk width.
  always_comb begin
    width_c    = CMP_W'(image_width);
    frame_done = (row >= image_height);
    wrap       = (CMP_W'(col) >= width_c);
    col_w      = wrap ? '0 : col;
    row_w      = wrap ? row + 1'b1 : row;
    done_w     = (row_w >= image_height);
    take       = pix_valid && !frame_done && !done_w;
    col_inc    = CMP_W'(col_w) + 1'b1;
    end_row    = (col_inc >= width_c);
    on_edge    = (row_w == '0) || (row_w == image_height - 1'b1) ||
                 (col_w == '0) || (CMP_W'(col_w) == width_c - 1'b1);
    mark       = (row_w != '0) && (col_w != '0);
  end

  // Counters and label history.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col              <= '0;
      row              <= '0;
      left_label       <= '0;
      upper_left_label <= '0;
      s_valid          <= 1'b0;
    end else begin
      s_valid <= take;
      if (pix_valid && !frame_done) begin
        if (!take) begin
          col <= '0;
          row <= row_w;
        end else if (end_row) begin
          col <= '0;
          row <= row_w + 1'b1;
        end else begin
          col <= col_inc[COL_W-1:0];
          row <= row_w;
        end
        if (take) begin
          left_label <= pix_label;
        end
      end
      if (s_valid) begin
        upper_left_label <= prev_q;
      end
    end
  end

  // Window payload captured with the pixel.
  always_ff @(posedge clk) begin
    if (take) begin
      s_col  <= col_w;
      s_ul   <= upper_left_label;
      s_ll   <= left_label;
      s_lr   <= pix_label;
      s_mark <= mark;
      s_edge <= on_edge;
    end
  end

  // Previous-row RAM: read above the pixel, write the pixel back in the following cycle.
  always_ff @(posedge clk) begin
    prev_q <= prev_row[col_w];
    if (s_valid) begin
      prev_row[s_col] <= s_lr;
    end
  end

  always_comb begin
    win.valid   = s_valid;
    win.mark    = s_mark;
    win.on_edge = s_edge;
    win.ul      = s_ul;
    win.ll      = s_ll;
    win.lr      = s_lr;
    win.ur      = prev_q;
  end

  // A window only follows a pixel beat.
  a_win_from_pixel: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> $past(pix_valid))
    else $error("window without a pixel");

  // The last pixel of a row wraps the column to zero.
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    take && end_row && !clear |=> col == '0)
    else $error("column did not wrap at end of row");

  // Pixels after a complete frame leave the position alone.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    pix_valid && frame_done && !clear |=> row == $past(row) && col == $past(col))
    else $error("position moved after frame end");

endmodule

/* rtl/superpixel_adjacency_builder.sv */
// Region adjacency graph builder for a superpixel label map. Labels stream in
// raster order; each pixel first reads the label above it from the
// previous-row RAM, then the four neighbor pairs of its 2x2 window are
// issued one per cycle into the single read port of the adjacency RAM, whose
// write-back overlaps the next beat. A query reads the same port, and its
// response is registered into the response slot; clear is held off while an
// adjacency write is in flight. The adjacency RAM holds the upper triangle only,
// one row per label, and row valid bits make a clear instant, so there is no clearing pass.
// Depends on sab_pkg, sab_scan and sab_adj_mem.
module superpixel_adjacency_builder import sab_pkg::*; #(
  parameter int NUM_LABELS = DEF_NUM_LABELS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  in_t                   req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output out_t                  rsp_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LBL_W = $clog2(NUM_LABELS);

  typedef enum logic [1:0] {ST_IDLE, ST_WIN, ST_PAIR, ST_QRY} state_t;

  state_t              state;
  logic [1:0]          pair_idx;
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  width_next;
  logic [HEIGHT_W-1:0] height_next;
  logic [NUM_LABELS-1:0] bnd_flags;

  logic [LABEL_W-1:0]  w_ul;
  logic [LABEL_W-1:0]  w_ll;
  logic [LABEL_W-1:0]  w_lr;
  logic [LABEL_W-1:0]  w_ur;
  logic                w_mark;

  logic                q_inrange;
  logic                q_bnd;
  logic                q_done;

  logic                accept;
  logic                pix_go;
  logic                qry_go;
  logic                clr_go;
  logic                frame_done;
  win_t                win;

  logic [LABEL_W-1:0]  pa;
  logic [LABEL_W-1:0]  pb;
  logic                pmark;
  logic                pair_ok;
  logic [LABEL_W-1:0]  q_lo;
  logic [LABEL_W-1:0]  q_hi;

  logic                rd_valid;
  logic                rd_query;
  logic [LBL_W-1:0]    rd_row;
  logic [LBL_W-1:0]    rd_col;
  logic                hit_valid;
  logic                hit;
  logic                adj_busy;

  function automatic logic in_range(input logic [LABEL_W-1:0] lab);
    in_range = (32'(lab) < NUM_LABELS);
  endfunction

  function automatic logic [LBL_W-1:0] to_idx(input logic [LABEL_W-1:0] lab);
    to_idx = LBL_W'(lab);
  endfunction

  // Request handshake: one beat at a time; a query needs a free response slot.
  always_comb begin
    req_ready = (state == ST_IDLE);
    if ((req_data.action == ACT_QUERY) && rsp_valid && !rsp_ready) begin
      req_ready = 1'b0;
    end
    if ((req_data.action == ACT_CLEAR) && adj_busy) begin
      req_ready = 1'b0;
    end
  end

  assign accept    = req_valid && req_ready;
  assign pix_go    = accept && (req_data.action == ACT_PIXEL);
  assign qry_go    = accept && (req_data.action == ACT_QUERY);
  assign clr_go    = accept && (req_data.action == ACT_CLEAR);
  assign cfg_ready = 1'b1;

  // Clamp register writes into their legal ranges.
  always_comb begin
    width_next  = cfg_data[WIDTH_W-1:0];
    height_next = cfg_data[HEIGHT_W-1:0];
    if (width_next < MIN_WIDTH) begin
      width_next = MIN_WIDTH;
    end else if (32'(width_next) > MAX_WIDTH) begin
      width_next = WIDTH_W'(MAX_WIDTH);
    end
    if (height_next < MIN_HEIGHT) begin
      height_next = MIN_HEIGHT;
    end else if (height_next > HEIGHT_LIMIT) begin
      height_next = HEIGHT_LIMIT;
    end
  end

  // Neighbor pair for this cycle: the first comes straight from the window,
  // the other three from the captured copy.
  always_comb begin
    if (state == ST_WIN) begin
      pa    = win.ul;
      pb    = win.ll;
      pmark = win.valid && win.mark;
    end else begin
      pmark = w_mark && (state == ST_PAIR);
      case (pair_idx)
        2'd1: begin
          pa = w_ul;
          pb = w_ur;
        end
        2'd2: begin
          pa = w_ul;
          pb = w_lr;
        end
        2'd3: begin
          pa = w_ll;
          pb = w_ur;
        end
        default: begin
          pa = w_ul;
          pb = w_ll;
        end
      endcase
    end
    pair_ok = pmark && (pa != pb) && in_range(pa) && in_range(pb);
  end

  // Adjacency RAM read: a query, or a pair update into the upper triangle.
  always_comb begin
    if (req_data.query_first < req_data.query_second) begin
      q_lo = req_data.query_first;
      q_hi = req_data.query_second;
    end else begin
      q_lo = req_data.query_second;
      q_hi = req_data.query_first;
    end
    if (qry_go) begin
      rd_valid = 1'b1;
      rd_query = 1'b1;
      rd_row   = to_idx(q_lo);
      rd_col   = to_idx(q_hi);
    end else begin
      rd_valid = pair_ok;
      rd_query = 1'b0;
      rd_row   = (pa < pb) ? to_idx(pa) : to_idx(pb);
      rd_col   = (pa < pb) ? to_idx(pb) : to_idx(pa);
    end
  end

  // Sequencer, registers, boundary flags and the response slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pair_idx     <= '0;
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      bnd_flags    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= width_next;
          REG_IMAGE_HEIGHT: image_height <= height_next;
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pix_go) begin
            state <= ST_WIN;
          end else if (qry_go) begin
            state <= ST_QRY;
          end else if (clr_go) begin
            bnd_flags <= '0;
          end
        end
        ST_WIN: begin
          if (win.valid) begin
            state    <= ST_PAIR;
            pair_idx <= 2'd1;
            if (win.on_edge && in_range(win.lr)) begin
              bnd_flags[to_idx(win.lr)] <= 1'b1;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAIR: begin
          if (pair_idx == 2'd3) begin
            state <= ST_IDLE;
          end else begin
            pair_idx <= pair_idx + 1'b1;
          end
        end
        ST_QRY: begin
          if (hit_valid) begin
            rsp_valid <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_WIN) begin
      w_ul   <= win.ul;
      w_ll   <= win.ll;
      w_lr   <= win.lr;
      w_ur   <= win.ur;
      w_mark <= win.mark;
    end
    if (qry_go) begin
      q_inrange <= in_range(req_data.query_first) && in_range(req_data.query_second);
      q_bnd     <= (req_data.query_first != req_data.query_second) &&
                   bnd_flags[to_idx(req_data.query_first)] &&
                   bnd_flags[to_idx(req_data.query_second)];
      q_done    <= frame_done;
    end
    if ((state == ST_QRY) && hit_valid) begin
      rsp_data.adjacent       <= q_inrange && (hit || q_bnd);
      rsp_data.frame_complete <= q_done;
    end
  end

  sab_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .clear        (clr_go),
    .pix_valid    (pix_go),
    .pix_label    (req_data.pixel_label),
    .image_width  (image_width),
    .image_height (image_height),
    .frame_done   (frame_done),
    .win          (win)
  );

  sab_adj_mem #(
    .NUM_LABELS (NUM_LABELS)
  ) u_adj (
    .clk       (clk),
    .rst       (rst),
    .clear     (clr_go),
    .rd_valid  (rd_valid),
    .rd_query  (rd_query),
    .rd_row    (rd_row),
    .rd_col    (rd_col),
    .hit_valid (hit_valid),
    .hit       (hit),
    .busy      (adj_busy)
  );

  // The adjacency response lands only in the query wait state.
  a_hit_in_qry: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> state == ST_QRY)
    else $error("adjacency response outside query wait");

  // A window only arrives while the sequencer expects it.
  a_win_in_state: assert property (@(posedge clk) disable iff (rst)
    win.valid |-> state == ST_WIN)
    else $error("window outside window state");

  // A query is taken only when its response will find the slot free.
  a_qry_slot: assert property (@(posedge clk) disable iff (rst)
    qry_go |-> !rsp_valid || rsp_ready)
    else $error("query accepted with response slot occupied");

endmodule

/* dv/sab_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the superpixel adjacency builder: it keeps its own adjacency
// graph, border labels and raster position, and queues the expected query answers.
// Depends on sab_pkg for the beat types, field widths and codes.
package sab_tb_pkg;
  import sab_pkg::*;

  localparam int LABELS = DEF_NUM_LABELS;
  localparam int ROW_SLOTS = DEF_MAX_WIDTH;
  localparam int REPORT_LIMIT = 10;

  // Codes that the block has no use for; it must ignore them.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 2'd3;

  class adjacency_scoreboard;
    logic [LABELS-1:0] adj_rows [LABELS];
    logic [LABELS-1:0] border_labels;
    logic [LABEL_W-1:0] row_above [ROW_SLOTS];
    logic [LABEL_W-1:0] left_lab;
    logic [LABEL_W-1:0] upleft_lab;
    int col;
    int row;
    int width;
    int height;
    int cols_written;
    out_t answers [$];
    int mismatches;

    function new();
      width = RESET_WIDTH;
      height = RESET_HEIGHT;
      mismatches = 0;
      wipe();
    endfunction

    // A clear empties the graph and restarts the raster position.
    function void wipe();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      foreach (row_above[i]) row_above[i] = '0;
      border_labels = '0;
      left_lab = '0;
      upleft_lab = '0;
      col = 0;
      row = 0;
      cols_written = 0;
    endfunction

    function bit frame_full();
      return row >= height;
    endfunction

    function void link(logic [LABEL_W-1:0] a, logic [LABEL_W-1:0] b);
      if (a != b) begin
        adj_rows[a][b] = 1'b1;
        adj_rows[b][a] = 1'b1;
      end
    endfunction

    // Returns 0 when the pixel is dropped because the frame is already full.
    function bit take_label(logic [LABEL_W-1:0] lab);
      logic [LABEL_W-1:0] above;
      if (frame_full()) return 1'b0;
      // A shrunk width leaves the column past the end: wrap first.
      if (col >= width) begin
        col = 0;
        row++;
        if (frame_full()) return 1'b1;
      end
      if (row == 0 || row == height - 1 || col == 0 || col == width - 1)
        border_labels[lab] = 1'b1;
      above = row_above[col];
      if (row >= 1 && col >= 1) begin
        link(upleft_lab, left_lab);
        link(upleft_lab, above);
        link(upleft_lab, lab);
        link(left_lab, above);
      end
      upleft_lab = above;
      left_lab = lab;
      row_above[col] = lab;
      if (col + 1 > cols_written) cols_written = col + 1;
      col++;
      if (col >= width) begin
        col = 0;
        row++;
      end
      return 1'b1;
    endfunction

    // Called on every accepted request beat; returns 0 if the block ignores it.
    function bit note_request(in_t req);
      out_t answer;
      case (req.action)
        ACT_PIXEL: return take_label(req.pixel_label);
        ACT_QUERY: begin
          answer.adjacent = adj_rows[req.query_first][req.query_second] ||
                            (req.query_first != req.query_second &&
                             border_labels[req.query_first] &&
                             border_labels[req.query_second]);
          answer.frame_complete = frame_full();
          answers.push_back(answer);
          return 1'b1;
        end
        ACT_CLEAR: begin
          wipe();
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Register writes are masked to the register width, then clamped.
    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int v;
      case (idx)
        REG_IMAGE_WIDTH: begin
          v = data[WIDTH_W-1:0];
          if (v < MIN_WIDTH) v = MIN_WIDTH;
          if (v > ROW_SLOTS) v = ROW_SLOTS;
          width = v;
        end
        REG_IMAGE_HEIGHT: begin
          v = data[HEIGHT_W-1:0];
          if (v < MIN_HEIGHT) v = MIN_HEIGHT;
          if (v > HEIGHT_LIMIT) v = HEIGHT_LIMIT;
          height = v;
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: response beat with no query waiting: adjacent %0b frame_complete %0b",
                   $realtime, got.adjacent, got.frame_complete);
        return;
      end
      want = answers.pop_front();
      if (got.adjacent !== want.adjacent || got.frame_complete !== want.frame_complete) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch adjacent exp %0b got %0b, frame_complete exp %0b got %0b",
                   $realtime, want.adjacent, got.adjacent, want.frame_complete,
                   got.frame_complete);
      end
    endfunction
  endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top-level testbench for superpixel_adjacency_builder: directed and random label
// streams, queries and clears, with random stalls on both sides of the block.
// Depends on sab_pkg and sab_tb_pkg.
module testbench;
  import sab_pkg::*;
  import sab_tb_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int CALM_ITEMS = 200;
  // Lets pixel work drain; a clear may wait on a write in flight.
  localparam int SETTLE = 16;
  // Longest quiet stretch: sender gap, settle, pixel work and a full sink stall.
  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adjacency_scoreboard board = new();
  int counted = 0;
  bit calm = 1'b0;
  int req_idle_pct = 0;
  int rsp_idle_pct = 0;
  logic [LABEL_W-1:0] palette [8];
  int palette_n = 2;

  always #1 clk = ~clk;

  superpixel_adjacency_builder uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic in_t compose(logic [ACTION_W-1:0] act, logic [LABEL_W-1:0] lab,
                                  logic [LABEL_W-1:0] qa, logic [LABEL_W-1:0] qb);
    in_t b;
    b.action = act;
    b.pixel_label = lab;
    b.query_first = qa;
    b.query_second = qb;
    return b;
  endfunction

  // Mostly labels of the current frame's palette, now and then any label.
  function automatic logic [LABEL_W-1:0] any_label();
    if ($urandom_range(0, 99) < 10) return $urandom_range(0, 255);
    return palette[$urandom_range(0, palette_n - 1)];
  endfunction

  // Register words: extremes are sometimes written out of range, and the
  // unused upper bits of the width word carry junk.
  function automatic logic [CFG_DATA_W-1:0] width_word(int w);
    logic [CFG_DATA_W-1:0] word;
    word = w;
    if (w == MIN_WIDTH && $urandom_range(0, 1)) word = $urandom_range(0, 2);
    else if (w == ROW_SLOTS && $urandom_range(0, 1)) word = $urandom_range(1024, 2047);
    word[CFG_DATA_W-1:WIDTH_W] = $urandom_range(0, 3);
    return word;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] height_word(int h);
    logic [CFG_DATA_W-1:0] word;
    word = h;
    if (h == MIN_HEIGHT && $urandom_range(0, 1)) word = $urandom_range(0, 2);
    else if (h == HEIGHT_LIMIT && $urandom_range(0, 1)) word = $urandom_range(4096, 8191);
    return word;
  endfunction

  // Random gap on the request side after an accepted beat.
  task automatic hold_off_maybe();
    if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic push_beat(in_t beat);
    req_valid <= 1'b1;
    req_data <= beat;
    do @(posedge clk); while (!req_ready);
    if (board.note_request(beat)) counted++;
    hold_off_maybe();
  endtask

  task automatic send_pixel(logic [LABEL_W-1:0] lab);
    push_beat(compose(ACT_PIXEL, lab, $urandom_range(0, 255), $urandom_range(0, 255)));
  endtask

  task automatic send_query(logic [LABEL_W-1:0] a, logic [LABEL_W-1:0] b);
    push_beat(compose(ACT_QUERY, $urandom_range(0, 255), a, b));
  endtask

  task automatic send_random_query();
    logic [LABEL_W-1:0] a;
    a = any_label();
    send_query(a, ($urandom_range(0, 9) == 0) ? a : any_label());
  endtask

  task automatic send_clear();
    push_beat(compose(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255)));
  endtask

  task automatic send_unused();
    push_beat(compose(ACT_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255)));
  endtask

  // Stop sending, wait for every answer, then let pixel work drain.
  task automatic quiesce();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.note_config(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  // Change the geometry mid-frame. The width only grows past the columns
  // already stored while the first row is still being filled.
  task automatic reshape();
    int bound;
    quiesce();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_IMAGE_HEIGHT, height_word($urandom_range(2, board.row + 4)), 1'b1);
    end else begin
      bound = (board.row == 0) ? 16 : board.cols_written;
      write_reg(REG_IMAGE_WIDTH, width_word($urandom_range(2, bound)), 1'b1);
    end
  endtask

  // One frame: clear, set the geometry, then stream labels mixed with queries.
  // A negative budget means the whole frame plus up to three pixels past its end.
  task automatic play_frame(logic [CFG_DATA_W-1:0] wword, logic [CFG_DATA_W-1:0] hword,
                            int budget);
    int placed;
    int r;
    logic [LABEL_W-1:0] base;
    send_clear();
    quiesce();
    write_reg(REG_IMAGE_WIDTH, wword, 1'b0);
    write_reg(REG_IMAGE_HEIGHT, hword, 1'b1);
    if (budget < 0) budget = board.width * board.height + $urandom_range(0, 3);
    palette_n = $urandom_range(2, 8);
    base = $urandom_range(0, 255);
    for (int i = 0; i < 8; i++) palette[i] = base + $urandom_range(0, 15);
    placed = 0;
    while (placed < budget) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        send_random_query();
      end else if (r < 20) begin
        send_unused();
      end else if (r == 20) begin
        send_clear();
      end else if (r == 21) begin
        reshape();
      end else begin
        send_pixel(any_label());
        placed++;
      end
    end
    repeat ($urandom_range(2, 5)) send_random_query();
  endtask

  // Response side: accept answers with random stall bursts.
  initial begin : response_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) board.check_response(rsp_data);
      if (stall > 0) begin
        stall--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rsp_idle_pct) begin
        stall = $urandom_range(0, 18);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int sel;
    int w;
    int h;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: start with the reset geometry, then shrink the width
    // in the middle of the first row so the next pixel wraps.
    send_query(8'h00, 8'hFF);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h5A);
    send_unused();
    quiesce();
    write_reg(REG_IMAGE_WIDTH, 13'd3, 1'b0);
    write_reg(REG_IMAGE_HEIGHT, 13'd3, 1'b1);
    send_pixel(8'hFF);
    send_pixel(8'h3C);
    send_pixel(8'h00);
    send_query(8'h3C, 8'h00);
    send_pixel(8'h5A);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
    // The frame is full, so this pixel is dropped.
    send_pixel(8'h11);
    send_query(8'h5A, 8'h5A);
    send_query(8'hFF, 8'h5A);
    send_query(8'h3C, 8'hFF);
    send_query(8'h11, 8'h00);
    send_clear();
    send_query(8'h00, 8'hFF);

    // Register extremes: clamped minimum, clamped maximum, unused indexes.
    quiesce();
    write_reg(REG_UNUSED_LO, $urandom_range(0, 8191), 1'b0);
    write_reg(REG_UNUSED_HI, $urandom_range(0, 8191), 1'b1);
    play_frame(13'h0000, 13'h0001, -1);
    play_frame(13'h1FFF, 13'h1FFF, 60);
    play_frame(width_word(3), 13'h1000, 50);
    play_frame(width_word(ROW_SLOTS), height_word(2), 80);

    // Random frames, mostly small, with varying stall pressure.
    while (counted < ITEM_TARGET) begin
      calm = counted >= ITEM_TARGET - CALM_ITEMS;
      sel = $urandom_range(0, 2);
      req_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 8 : 30;
      sel = $urandom_range(0, 2);
      rsp_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 8 : 30;
      if ($urandom_range(0, 99) < 8) begin
        w = $urandom_range(0, 1) ? ROW_SLOTS : $urandom_range(100, ROW_SLOTS);
        h = $urandom_range(0, 1) ? int'(HEIGHT_LIMIT) : $urandom_range(2, HEIGHT_LIMIT);
        play_frame(width_word(w), height_word(h), $urandom_range(30, 60));
      end else begin
        w = $urandom_range(2, 12);
        h = $urandom_range(2, 10);
        play_frame(width_word(w), height_word(h), -1);
      end
    end

    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
